### src/dflp_pkg.sv
// ----------------------------------------------------------------------------
// dflp_pkg
// Shared types, codes and helpers for the descriptor free list pool.
// ----------------------------------------------------------------------------
package dflp_pkg;

  // Field widths fixed by the item format
  localparam int IDX_W    = 8;
  localparam int QSIZE_W  = 9;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 3;
  localparam int ENTRY_W  = IDX_W + 1;  // {chain flag, link}

  // Pool defaults
  localparam int MAX_DESCRIPTORS  = 256;
  localparam logic [QSIZE_W-1:0] QUEUE_SIZE_RESET = 9'd64;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_LINK  = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 2'd2;

  // Register index (paddr[2])
  localparam logic REG_QUEUE_SIZE = 1'b0;

  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_LINK,
    KIND_FREE,
    KIND_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   tgt;
    logic               lv;
  } cmd_t;

  typedef struct packed {
    logic               init;     // pool re-initialization this cycle
    logic [QSIZE_W-1:0] init_qs;  // effective size that takes effect
    logic [QSIZE_W-1:0] qs;       // effective size in force
  } cfg_t;

  // Clamp a raw queue size to 1..max_desc
  function automatic logic [QSIZE_W-1:0] eff_size(input logic [QSIZE_W-1:0] raw,
                                                  input int unsigned max_desc);
    logic [QSIZE_W-1:0] q;
    q = raw;
    if (raw == '0) begin
      q = 9'd1;
    end else if (int'(raw) > int'(max_desc)) begin
      q = QSIZE_W'(max_desc);
    end
    return q;
  endfunction

endpackage

### src/dflp_if.sv
// ----------------------------------------------------------------------------
// dflp_cmd_if / dflp_res_if
// Valid/ready channels for pool commands and pool results.
// ----------------------------------------------------------------------------
interface dflp_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [dflp_pkg::OP_W-1:0]     operation;
  logic [dflp_pkg::IDX_W-1:0]    desc_index;
  logic [dflp_pkg::IDX_W-1:0]    link_target;
  logic                          link_valid;

  modport source (output valid, operation, desc_index, link_target, link_valid,
                  input ready);
  modport sink (input valid, operation, desc_index, link_target, link_valid,
                output ready);
endinterface

interface dflp_res_if;
  logic                          valid;
  logic                          ready;
  logic [dflp_pkg::IDX_W-1:0]    granted_index;
  logic [dflp_pkg::STATUS_W-1:0] status;
  logic [dflp_pkg::QSIZE_W-1:0]  free_count;

  modport source (output valid, granted_index, status, free_count, input ready);
  modport sink (input valid, granted_index, status, free_count, output ready);
endinterface

### src/dflp_ram.sv
// ----------------------------------------------------------------------------
// dflp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dflp_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### src/dflp_front.sv
// ----------------------------------------------------------------------------
// dflp_front
// Accept command words, decode them and hold them in a short queue.
// ----------------------------------------------------------------------------
module dflp_front (
  input  logic              clk,
  input  logic              rst,
  dflp_cmd_if.sink          cmd,
  output logic              q_valid,
  input  logic              q_ready,
  output dflp_pkg::cmd_t    q_cmd
);

  dflp_pkg::cmd_t                   q_mem [dflp_pkg::CMDQ_DEPTH];
  logic [dflp_pkg::CMDQ_PTR_W-1:0]  wr_ptr;
  logic [dflp_pkg::CMDQ_PTR_W-1:0]  rd_ptr;
  logic [dflp_pkg::CMDQ_CNT_W-1:0]  count;
  dflp_pkg::cmd_t                   decoded;
  logic                             push;
  logic                             pop;

  // Classify the incoming word
  always_comb begin
    decoded.idx = cmd.desc_index;
    decoded.tgt = cmd.link_target;
    decoded.lv  = cmd.link_valid;
    case (cmd.operation)
      dflp_pkg::OP_ALLOC: decoded.kind = dflp_pkg::KIND_ALLOC;
      dflp_pkg::OP_LINK:  decoded.kind = dflp_pkg::KIND_LINK;
      dflp_pkg::OP_FREE:  decoded.kind = dflp_pkg::KIND_FREE;
      default:            decoded.kind = dflp_pkg::KIND_NOP;
    endcase
  end

  assign cmd.ready = (count != dflp_pkg::CMDQ_CNT_W'(dflp_pkg::CMDQ_DEPTH));
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != '0);
  assign pop       = q_valid && q_ready;
  assign q_cmd     = q_mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= decoded;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/dflp_back.sv
// ----------------------------------------------------------------------------
// dflp_back
// Execute pool commands against the link RAM and drive the result register.
// ----------------------------------------------------------------------------
module dflp_back #(
  parameter int MaxDesc = dflp_pkg::MAX_DESCRIPTORS
) (
  input  logic              clk,
  input  logic              rst,
  input  dflp_pkg::cfg_t    cfg,
  input  logic              q_valid,
  output logic              q_ready,
  input  dflp_pkg::cmd_t    q_cmd,
  dflp_res_if.source        res
);

  localparam int AW = $clog2(MaxDesc);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_DATA,
    S_CHK_ADDR,
    S_CHK_DATA,
    S_PUSH_ADDR,
    S_PUSH_DATA
  } state_t;

  state_t                              state;
  logic [dflp_pkg::IDX_W-1:0]          list_head;
  logic [dflp_pkg::QSIZE_W-1:0]        free_total;
  logic [dflp_pkg::IDX_W-1:0]          cur;
  logic [dflp_pkg::IDX_W-1:0]          head_idx;
  logic [dflp_pkg::QSIZE_W-1:0]        count;
  logic [dflp_pkg::QSIZE_W-1:0]        room;
  logic [dflp_pkg::QSIZE_W:0]          count_inc;
  logic [AW-1:0]                       rd_idx;
  logic [MaxDesc-1:0]                  entry_valid;

  logic                                res_valid;
  logic [dflp_pkg::IDX_W-1:0]          res_granted;
  logic [dflp_pkg::STATUS_W-1:0]       res_status;
  logic [dflp_pkg::QSIZE_W-1:0]        res_free;

  logic                                ram_we;
  logic [AW-1:0]                       ram_waddr;
  logic [dflp_pkg::ENTRY_W-1:0]        ram_wdata;
  logic [AW-1:0]                       ram_raddr;
  logic [dflp_pkg::ENTRY_W-1:0]        ram_rdata;
  logic [dflp_pkg::IDX_W-1:0]          eff_link;
  logic                                eff_flag;
  logic                                pop;

  dflp_ram #(
    .Width (dflp_pkg::ENTRY_W),
    .Depth (MaxDesc)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entries never written read as their reset link with no chain flag
  assign eff_flag = entry_valid[rd_idx] ? ram_rdata[dflp_pkg::IDX_W] : 1'b0;
  assign eff_link = entry_valid[rd_idx] ? ram_rdata[dflp_pkg::IDX_W-1:0]
                                        : dflp_pkg::IDX_W'(rd_idx) + 1'b1;

  assign q_ready   = (state == S_IDLE) && !res_valid && !cfg.init;
  assign pop       = q_valid && q_ready;
  assign count_inc = {1'b0, count} + 1'b1;

  // Drive the RAM ports
  always_comb begin
    ram_raddr = (state == S_IDLE) ? list_head[AW-1:0] : cur[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = cur[AW-1:0];
    ram_wdata = {eff_flag, list_head};
    case (state)
      S_IDLE: begin
        if (pop && q_cmd.kind == dflp_pkg::KIND_LINK &&
            {1'b0, q_cmd.idx} < cfg.qs) begin
          ram_we    = 1'b1;
          ram_waddr = q_cmd.idx[AW-1:0];
          ram_wdata = {q_cmd.lv, q_cmd.tgt};
        end
      end
      S_ALLOC_DATA: begin
        ram_we    = 1'b1;
        ram_waddr = list_head[AW-1:0];
        ram_wdata = '0;
      end
      S_PUSH_DATA: begin
        ram_we    = 1'b1;
      end
      default: begin
        ram_we    = 1'b0;
      end
    endcase
  end

  // Mark written entries; reset and re-initialization clear all marks
  always_ff @(posedge clk) begin
    if (rst || cfg.init) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[ram_waddr] <= 1'b1;
    end
  end

  // Sequencer, pool registers and result register
  always_ff @(posedge clk) begin
    rd_idx <= ram_raddr;
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      list_head  <= '0;
      free_total <= dflp_pkg::eff_size(dflp_pkg::QUEUE_SIZE_RESET, MaxDesc);
    end else if (cfg.init) begin
      list_head  <= '0;
      free_total <= cfg.init_qs;
    end else begin
      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            res_granted <= '0;
            res_status  <= (q_cmd.kind == dflp_pkg::KIND_ALLOC && free_total == '0)
                           ? dflp_pkg::STATUS_EMPTY : dflp_pkg::STATUS_OK;
            res_free    <= free_total;
            case (q_cmd.kind)
              dflp_pkg::KIND_ALLOC: begin
                if (free_total == '0) begin
                  res_valid  <= 1'b1;
                end else begin
                  state <= S_ALLOC_DATA;
                end
              end
              dflp_pkg::KIND_FREE: begin
                room     <= (free_total <= cfg.qs) ? cfg.qs - free_total : '0;
                count    <= '0;
                cur      <= q_cmd.idx;
                head_idx <= q_cmd.idx;
                state    <= S_CHK_ADDR;
              end
              default: begin
                res_valid <= 1'b1;
              end
            endcase
          end
        end
        S_ALLOC_DATA: begin
          list_head   <= eff_link;
          free_total  <= free_total - 1'b1;
          res_granted <= list_head;
          res_free    <= free_total - 1'b1;
          res_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        S_CHK_ADDR: begin
          // Reject indexes outside the pool and walks longer than allowed
          if ({1'b0, cur} >= cfg.qs || count_inc > {1'b0, room}) begin
            res_status <= dflp_pkg::STATUS_MALFORMED;
            res_valid  <= 1'b1;
            state      <= S_IDLE;
          end else begin
            count <= count_inc[dflp_pkg::QSIZE_W-1:0];
            state <= S_CHK_DATA;
          end
        end
        S_CHK_DATA: begin
          if (eff_flag) begin
            cur   <= eff_link;
            state <= S_CHK_ADDR;
          end else begin
            cur   <= head_idx;
            state <= S_PUSH_ADDR;
          end
        end
        S_PUSH_ADDR: begin
          state <= S_PUSH_DATA;
        end
        S_PUSH_DATA: begin
          // Push the descriptor onto the free list
          list_head  <= cur;
          free_total <= free_total + 1'b1;
          if (eff_flag) begin
            cur   <= eff_link;
            state <= S_PUSH_ADDR;
          end else begin
            res_free  <= free_total + 1'b1;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid         = res_valid;
  assign res.granted_index = res_granted;
  assign res.status        = res_status;
  assign res.free_count    = res_free;

`ifndef NO_ASSERTIONS
  a_free_bounded: assert property (@(posedge clk) disable iff (rst)
    free_total <= cfg.qs)
    else $error("free_total exceeds queue size");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status == dflp_pkg::STATUS_EMPTY) |->
      (res_granted == '0 && res_free == '0))
    else $error("empty result carries a grant or a nonzero count");

  a_alloc_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC_DATA && !cfg.init) |=> free_total == $past(free_total) - 1'b1)
    else $error("allocate did not take exactly one descriptor");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !q_ready)
    else $error("command taken while a walk is in progress");
`endif

endmodule

### src/descriptor_free_list_pool.sv
// ----------------------------------------------------------------------------
// descriptor_free_list_pool
// LIFO descriptor free list with allocate, link and chain free commands.
// ----------------------------------------------------------------------------
// Commands enter on cmd (valid/ready) and each produces one word on res.
// A two-entry command queue lets cmd keep accepting while the executor is
// busy or res is stalled; the result register holds its word until taken.
// Execution per command, from leaving the queue to the result word:
//   allocate does one link RAM read; empty allocate, link and unused codes
//   answer without a link RAM read; free chain checks each entry of the chain,
//   then pushes each one, reading every entry through the single RAM read port.
// A new command starts only after the previous result has been taken.
// The APB port holds queue_size at byte address 0; writing it rebuilds
// the free list at once and must only happen while the block is idle.
// Reset is synchronous: queue_size returns to 64, the list is rebuilt as
// 0..size-1 and the queue and result register are emptied. No clearing
// pass is needed; per-entry written marks make untouched links read as
// their reset value.
// ----------------------------------------------------------------------------
module descriptor_free_list_pool #(
  parameter int MaxDesc = dflp_pkg::MAX_DESCRIPTORS
) (
  input  logic                          clk,
  input  logic                          rst,
  dflp_cmd_if.sink                      cmd,
  dflp_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dflp_pkg::PADDR_W-1:0]  paddr,
  input  logic [dflp_pkg::PDATA_W-1:0]  pwdata,
  output logic [dflp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic [dflp_pkg::QSIZE_W-1:0] queue_size;
  logic                         cfg_write;
  dflp_pkg::cfg_t               cfg;
  logic                         q_valid;
  logic                         q_ready;
  dflp_pkg::cmd_t               q_cmd;

  // Register file access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == dflp_pkg::REG_QUEUE_SIZE);
  assign prdata    = (paddr[2] == dflp_pkg::REG_QUEUE_SIZE)
                     ? {{(dflp_pkg::PDATA_W - dflp_pkg::QSIZE_W){1'b0}}, queue_size}
                     : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_size <= dflp_pkg::QUEUE_SIZE_RESET;
    end else if (cfg_write) begin
      queue_size <= pwdata[dflp_pkg::QSIZE_W-1:0];
    end
  end

  assign cfg.init    = cfg_write;
  assign cfg.init_qs = dflp_pkg::eff_size(pwdata[dflp_pkg::QSIZE_W-1:0], MaxDesc);
  assign cfg.qs      = dflp_pkg::eff_size(queue_size, MaxDesc);

  dflp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd)
  );

  dflp_back #(
    .MaxDesc (MaxDesc)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd),
    .res     (res)
  );

endmodule
